// ----- sv/ita_pkg.sv -----
// Shared types, codes and helpers for the integer-to-ASCII formatter.
// No dependencies.
package ita_pkg;

  localparam int MAG_W  = 64;
  localparam int DIG_N  = 16;
  localparam int CNT_W  = 5;

  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_SHEX = 2'd1;
  localparam logic [1:0] KIND_PTR  = 2'd2;
  localparam logic [1:0] KIND_UDEC = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A_OFS = 8'h57;

  // 2^35 / 10, rounded up; exact quotient for any 32-bit dividend
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_MINUS,
    PRE_ZERO,
    PRE_X
  } pre_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_CONV,
    BS_EMIT
  } back_state_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             hex;
    pre_t             pre;
  } entry_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_A_OFS + {4'b0, d};
    end
    return c;
  endfunction

endpackage

// ----- sv/ita_ifs.sv -----
// Valid/ready channel interfaces for the formatter's input and result sides.
// Depends on nothing.
interface ita_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ita_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last;
  modport source (output valid, ascii_char, last, input ready);
  modport sink   (input valid, ascii_char, last, output ready);
endinterface

// ----- sv/ita_front.sv -----
// Front end: takes input transfers, works out sign, magnitude, base and
// prefix, and holds up to two classified entries. Uses ita_pkg, ita_in_if.
module ita_front (
  input  logic            clk,
  input  logic            rst_n,
  ita_in_if.sink          in_ch,
  output logic            deq_valid,
  input  logic            deq_ready,
  output ita_pkg::entry_t deq_entry
);

  ita_pkg::entry_t q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      fill_r, fill_nxt;

  ita_pkg::entry_t cls;
  logic [31:0]     low;
  logic            neg;
  logic            push, pop;

  always_comb begin
    low = in_ch.value[31:0];
    neg = low[31] && ((in_ch.kind == ita_pkg::KIND_SDEC) || (in_ch.kind == ita_pkg::KIND_SHEX));
    cls.hex = (in_ch.kind == ita_pkg::KIND_SHEX) || (in_ch.kind == ita_pkg::KIND_PTR);
    if (in_ch.kind == ita_pkg::KIND_PTR) begin
      cls.mag = in_ch.value;
      cls.pre = ita_pkg::PRE_ZERO;
    end else if (neg) begin
      cls.mag = {32'b0, (~low) + 32'd1};
      cls.pre = ita_pkg::PRE_MINUS;
    end else begin
      cls.mag = {32'b0, low};
      cls.pre = ita_pkg::PRE_NONE;
    end
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign deq_valid   = (fill_r != 2'd0);
  assign pop         = deq_valid && deq_ready;
  assign deq_entry   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- sv/ita_back.sv -----
// Back end: peels digits off the magnitude one per cycle into a digit stack,
// then sends prefix and digits out through an output register. Uses ita_pkg.
module ita_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            deq_valid,
  output logic            deq_ready,
  input  ita_pkg::entry_t deq_entry,
  ita_out_if.source       out_ch
);

  ita_pkg::back_state_t       state_r, state_nxt;
  logic [ita_pkg::MAG_W-1:0]  mag_r, mag_nxt;
  logic                       hex_r, hex_nxt;
  ita_pkg::pre_t              pre_r, pre_nxt;
  logic [ita_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]                 dbuf_r [ita_pkg::DIG_N];
  logic [3:0]                 dbuf_nxt [ita_pkg::DIG_N];
  logic                       ov_r, ov_nxt;
  logic [7:0]                 och_r, och_nxt;
  logic                       olast_r, olast_nxt;

  logic [63:0]                prod;
  logic [31:0]                q10;
  logic [31:0]                q10x;
  logic [3:0]                 dig;
  logic [ita_pkg::MAG_W-1:0]  quo;

  // one digit per cycle: nibble shift for hex, reciprocal multiply for decimal
  always_comb begin
    prod = {32'b0, mag_r[31:0]} * {32'b0, ita_pkg::RECIP10};
    q10  = {3'b0, prod[63:35]};
    q10x = {q10[28:0], 3'b0} + {q10[30:0], 1'b0};
    if (hex_r) begin
      dig = mag_r[3:0];
      quo = {4'b0, mag_r[63:4]};
    end else begin
      dig = 4'(mag_r[31:0] - q10x);
      quo = {32'b0, q10};
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.ascii_char = och_r;
  assign out_ch.last       = olast_r;

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    hex_nxt   = hex_r;
    pre_nxt   = pre_r;
    cnt_nxt   = cnt_r;
    dbuf_nxt  = dbuf_r;
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    deq_ready = 1'b0;
    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      ita_pkg::BS_IDLE: begin
        deq_ready = 1'b1;
        if (deq_valid) begin
          mag_nxt   = deq_entry.mag;
          hex_nxt   = deq_entry.hex;
          pre_nxt   = deq_entry.pre;
          cnt_nxt   = '0;
          state_nxt = ita_pkg::BS_CONV;
        end
      end
      ita_pkg::BS_CONV: begin
        dbuf_nxt[0] = dig;
        for (int i = 1; i < ita_pkg::DIG_N; i++) begin
          dbuf_nxt[i] = dbuf_r[i-1];
        end
        cnt_nxt = cnt_r + 5'd1;
        mag_nxt = quo;
        if (quo == '0) begin
          state_nxt = ita_pkg::BS_EMIT;
        end
      end
      ita_pkg::BS_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          case (pre_r)
            ita_pkg::PRE_MINUS: begin
              och_nxt   = ita_pkg::CH_MINUS;
              olast_nxt = 1'b0;
              pre_nxt   = ita_pkg::PRE_NONE;
            end
            ita_pkg::PRE_ZERO: begin
              och_nxt   = ita_pkg::CH_ZERO;
              olast_nxt = 1'b0;
              pre_nxt   = ita_pkg::PRE_X;
            end
            ita_pkg::PRE_X: begin
              och_nxt   = ita_pkg::CH_X;
              olast_nxt = 1'b0;
              pre_nxt   = ita_pkg::PRE_NONE;
            end
            default: begin
              och_nxt   = ita_pkg::digit_char(dbuf_r[0]);
              olast_nxt = (cnt_r == 5'd1);
              for (int i = 0; i < ita_pkg::DIG_N - 1; i++) begin
                dbuf_nxt[i] = dbuf_r[i+1];
              end
              dbuf_nxt[ita_pkg::DIG_N-1] = 4'd0;
              cnt_nxt = cnt_r - 5'd1;
              if (cnt_r == 5'd1) begin
                state_nxt = ita_pkg::BS_IDLE;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = ita_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ita_pkg::BS_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    hex_r   <= hex_nxt;
    pre_r   <= pre_nxt;
    cnt_r   <= cnt_nxt;
    dbuf_r  <= dbuf_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

endmodule

// ----- sv/integer_to_ascii_formatter.sv -----
// Top level of the integer-to-ASCII formatter: front classifier/queue and
// back digit engine. Uses ita_pkg, ita_ifs, ita_front, ita_back.
//
//   channel  dir  payload                 transfer when
//   in_ch    in   kind[1:0], value[63:0]  valid && ready
//   out_ch   out  ascii_char[7:0], last   valid && ready
//
// An item with n digits and p prefix chars is loaded from the front queue, runs
// through the digit loop (one digit per cycle) and then sends p + n chars out.
// The front queue holds up to two items, so input is accepted while the back
// end works until the queue is full. Synchronous active-low reset empties the queue
// and drops any pending output; out_ch stalls hold the output register.
module integer_to_ascii_formatter (
  input  logic      clk,
  input  logic      rst_n,
  ita_in_if.sink    in_ch,
  ita_out_if.source out_ch
);

  logic            deq_valid;
  logic            deq_ready;
  ita_pkg::entry_t deq_entry;

  ita_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_entry (deq_entry)
  );

  ita_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_entry (deq_entry),
    .out_ch    (out_ch)
  );

endmodule

// ----- sv/ita_checker.sv -----
// Port-level checks for the formatter, bound to the top level.
// Uses ita_pkg.
module ita_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");

  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= ita_pkg::CH_ZERO && out_char <= 8'h39) ||
                  (out_char >= 8'h61 && out_char <= 8'h66) ||
                  out_char == ita_pkg::CH_MINUS || out_char == ita_pkg::CH_X)
    else $error("illegal character");

  a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == ita_pkg::CH_MINUS || out_char == ita_pkg::CH_X) |-> !out_last)
    else $error("prefix marked last");

  // first cycle an x shows up, a non-final zero was transferred just before
  a_x_follows_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == ita_pkg::CH_X &&
      !($past(out_valid) && $past(out_char) == ita_pkg::CH_X) |->
      $past(out_valid && out_ready) && $past(out_char) == ita_pkg::CH_ZERO &&
      !$past(out_last))
    else $error("x without leading zero");

endmodule

bind integer_to_ascii_formatter ita_checker u_ita_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.ascii_char),
  .out_last  (out_ch.last)
);

// ----- dv/ita_text_checker.sv -----
// Watches the formatter's input and result channels, predicts the text of each accepted value
// and compares it character by character. Uses ita_pkg and the interfaces in ita_ifs.
module ita_text_checker (
  input  logic clk,
  input  logic rst_n,
  ita_in_if    in_mon,
  ita_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);

  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    return (d < 4'd10) ? ita_pkg::CH_ZERO + {4'b0, d} : CH_LOWER_A + {4'b0, d} - 8'd10;
  endfunction

  function automatic void render_text(input logic [1:0] kind, input logic [63:0] value);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [31:0] low;
    low   = value[31:0];
    radix = 64'd10;
    mag   = {32'b0, low};
    case (kind)
      ita_pkg::KIND_SDEC, ita_pkg::KIND_SHEX: begin
        if (kind == ita_pkg::KIND_SHEX) radix = 64'd16;
        if (low[31]) begin
          text.push_back(ita_pkg::CH_MINUS);
          mag = {32'b0, ~low + 32'd1};
        end
      end
      ita_pkg::KIND_PTR: begin
        text.push_back(ita_pkg::CH_ZERO);
        text.push_back(ita_pkg::CH_X);
        radix = 64'd16;
        mag   = value;
      end
      default: ;
    endcase
    do begin
      digits.push_front(digit_glyph(4'(mag % radix)));
      mag = mag / radix;
    end while (mag != 64'd0);
    foreach (digits[j]) text.push_back(digits[j]);
    foreach (text[j]) expected_text.push_back('{ch: text[j], last: (j == text.size() - 1)});
  endfunction

  always @(posedge clk) begin : watch
    text_char_t want;
    if (!rst_n) begin
      expected_text.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) render_text(in_mon.kind, in_mon.value);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character transfer: ascii_char %h last %b",
                 out_mon.ascii_char, out_mon.last);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_mon.ascii_char !== want.ch) begin
            $error("ascii_char mismatch: expected %h, actual %h", want.ch, out_mon.ascii_char);
            fail_count++;
          end
          if (out_mon.last !== want.last) begin
            $error("last mismatch: expected %b, actual %b", want.last, out_mon.last);
            fail_count++;
          end
        end
      end
    end
    outstanding = expected_text.size();
  end

endmodule

// ----- dv/integer_to_ascii_formatter_tb.sv -----
// Top of the formatter regression: clock, reset, stimulus and receiver stalls around uut,
// with ita_text_checker scoring results. Uses ita_pkg, ita_ifs and the formatter RTL.
module integer_to_ascii_formatter_tb;

  localparam int N_RANDOM        = 148;
  localparam int IDLE_PCT        = 21;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;

  logic clk;
  logic rst_n;
  int   send_idle_pct = IDLE_PCT;
  int   recv_idle_pct = IDLE_PCT;
  bit   hold_off_req  = 1'b0;
  int   fail_count;
  int   outstanding;

  ita_in_if  in_ch ();
  ita_out_if out_ch ();

  integer_to_ascii_formatter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ita_text_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("integer_to_ascii_formatter regression: fail");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    logic [31:0] near;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: ;
      1: v = v & (64'hffff_ffff_ffff_ffff >> $urandom_range(63));
      2: v[31:0] = $urandom_range(20);
      default: begin
        near = $urandom_range(300);
        v[31:0] = $urandom_range(1) ? 32'h8000_0000 + near : 32'hffff_ffff - near;
      end
    endcase
    return v;
  endfunction

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.kind  <= ita_pkg::KIND_SDEC;
    in_ch.value <= 64'd0;
    rst_n       <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(ita_pkg::KIND_SDEC, 64'd0);
    send_item(ita_pkg::KIND_SDEC, 64'd1);
    send_item(ita_pkg::KIND_SDEC, 64'd9);
    send_item(ita_pkg::KIND_SDEC, 64'd10);
    send_item(ita_pkg::KIND_SDEC, 64'h0000_0000_7fff_ffff);
    send_item(ita_pkg::KIND_SDEC, 64'h0000_0000_ffff_ffff);
    send_item(ita_pkg::KIND_SDEC, 64'h0000_0000_8000_0000);
    send_item(ita_pkg::KIND_SDEC, 64'hdead_beef_0000_0005);
    send_item(ita_pkg::KIND_SHEX, 64'd0);
    send_item(ita_pkg::KIND_SHEX, 64'h0000_0000_0000_000f);
    send_item(ita_pkg::KIND_SHEX, 64'h0000_0000_7fff_ffff);
    send_item(ita_pkg::KIND_SHEX, 64'h0000_0000_8000_0000);
    send_item(ita_pkg::KIND_SHEX, 64'h0000_0000_ffff_ffff);
    send_item(ita_pkg::KIND_SHEX, 64'hffff_ffff_0000_abcd);
    send_item(ita_pkg::KIND_PTR,  64'd0);
    send_item(ita_pkg::KIND_PTR,  64'hffff_ffff_ffff_ffff);
    send_item(ita_pkg::KIND_PTR,  64'h8000_0000_0000_0000);
    send_item(ita_pkg::KIND_PTR,  64'h0123_4567_89ab_cdef);
    send_item(ita_pkg::KIND_UDEC, 64'd0);
    send_item(ita_pkg::KIND_UDEC, 64'h0000_0000_ffff_ffff);
    send_item(ita_pkg::KIND_UDEC, 64'h1234_5678_0000_0000);
    send_item(ita_pkg::KIND_UDEC, 64'd1_000_000_000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 40) hold_off_req = 1'b1;
      if (i == 100) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 135) begin
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;
      end
      send_item(2'($urandom_range(3)), random_value());
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("integer_to_ascii_formatter regression: pass");
    end else begin
      $display("integer_to_ascii_formatter regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/ita_pkg.sv
sv/ita_ifs.sv
sv/ita_front.sv
sv/ita_back.sv
sv/integer_to_ascii_formatter.sv
sv/ita_checker.sv
dv/ita_text_checker.sv
dv/integer_to_ascii_formatter_tb.sv
